// File: sv/ntc_voltage_to_temperature_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef NTC_VOLTAGE_TO_TEMPERATURE_UNIT_MACROS_SVH
`define NTC_VOLTAGE_TO_TEMPERATURE_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NTC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ntc_pkg.sv
`default_nettype none
package ntc_pkg;

    localparam int FRAC_BITS = 24;

    // log2 unit
    localparam int LOG_IN_W = 20;
    localparam int K_W      = 5;
    localparam int LOG_W    = K_W + FRAC_BITS;
    localparam int LOG_LAT  = FRAC_BITS + 1;

    // polynomial datapath
    localparam int MAG_W    = FRAC_BITS + 6;
    localparam int LN2_W    = 26;
    localparam logic [LN2_W-1:0] LN2_Q26 = 26'd46516320;
    localparam int PROD_W   = MAG_W + LN2_W;
    localparam int LQ_SHIFT = FRAC_BITS - 16;
    localparam int LQ_HALF  = (2 ** LQ_SHIFT) / 2;
    localparam int LQ_W     = 22;
    localparam int SQ_W     = 28;
    localparam int CU_W     = 32;
    localparam int COEF_W   = 32;
    localparam int BL_W     = COEF_W + LQ_W;
    localparam int CC_W     = COEF_W + CU_W;
    localparam int D_W      = 66;
    localparam int POLY_LAT = 8;

    // divider
    localparam int Q_W      = 16;
    localparam int UD_W     = 64;
    localparam int N_W      = UD_W + 1;
    localparam int R_W      = UD_W + Q_W;
    localparam int DIV_LAT  = Q_W + 3;
    localparam logic [UD_W-1:0] NUM_T = 64'd6553600000000000000;
    localparam logic [Q_W-1:0]  Q_MAX = 16'd60083;
    localparam logic signed [16:0] KELVIN_CENTI = 17'sd27316;
    localparam logic signed [15:0] TEMP_MAX = 16'sd32767;
    localparam logic signed [15:0] TEMP_MIN = -16'sd27316;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVER = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    // register map
    localparam int CFG_ADDR_W = 5;
    localparam logic [2:0] REG_SUPPLY = 3'd0;
    localparam logic [2:0] REG_SERIES = 3'd1;
    localparam logic [2:0] REG_COEF_A = 3'd2;
    localparam logic [2:0] REG_COEF_B = 3'd3;
    localparam logic [2:0] REG_COEF_C = 3'd4;

    typedef struct packed {
        logic        valid;
        logic [1:0]  status;
    } ctl_t;

    typedef struct packed {
        logic [12:0]       supply_mv;
        logic [19:0]       series_ohms;
        logic [COEF_W-1:0] coef_a;
        logic [COEF_W-1:0] coef_b;
        logic [COEF_W-1:0] coef_c;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        supply_mv:   13'd3300,
        series_ohms: 20'd10000,
        coef_a:      32'd1129000000,
        coef_b:      32'd234100000,
        coef_c:      32'd87670
    };

endpackage
`default_nettype wire

// File: sv/ntc_cfg.sv
`default_nettype none
module ntc_cfg
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [ntc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                      pwdata,
    output logic      [31:0]                      prdata,
    output logic                                  pready,
    output ntc_pkg::cfg_t                         cfg
);

    ntc_pkg::cfg_t cfg_reg;
    logic [2:0]    reg_idx;
    logic          wr_en;

    assign reg_idx = paddr[ntc_pkg::CFG_ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= ntc_pkg::CFG_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                ntc_pkg::REG_SUPPLY: cfg_reg.supply_mv   <= pwdata[12:0];
                ntc_pkg::REG_SERIES: cfg_reg.series_ohms <= pwdata[19:0];
                ntc_pkg::REG_COEF_A: cfg_reg.coef_a      <= pwdata;
                ntc_pkg::REG_COEF_B: cfg_reg.coef_b      <= pwdata;
                ntc_pkg::REG_COEF_C: cfg_reg.coef_c      <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            ntc_pkg::REG_SUPPLY: prdata = {19'd0, cfg_reg.supply_mv};
            ntc_pkg::REG_SERIES: prdata = {12'd0, cfg_reg.series_ohms};
            ntc_pkg::REG_COEF_A: prdata = cfg_reg.coef_a;
            ntc_pkg::REG_COEF_B: prdata = cfg_reg.coef_b;
            ntc_pkg::REG_COEF_C: prdata = cfg_reg.coef_c;
            default:             prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

// File: sv/ntc_log2.sv
`default_nettype none
module ntc_log2
(
    input  wire logic                           clk,
    input  wire logic                           en,
    input  wire logic [ntc_pkg::LOG_IN_W-1:0]   n,
    output logic      [ntc_pkg::LOG_W-1:0]      log2_val
);

    localparam int F = ntc_pkg::FRAC_BITS;

    logic [ntc_pkg::K_W-1:0] k_next;
    logic [31:0]             x_next;

    logic [31:0]             x_reg    [0:F-1];
    logic [F-1:0]            frac_reg [1:F];
    logic [ntc_pkg::K_W-1:0] k_reg    [0:F];
    logic [63:0]             sq_w     [1:F];

    // leading one: the highest set bit wins
    always_comb
    begin
        k_next = '0;
        for (int i = 1; i < ntc_pkg::LOG_IN_W; i++)
        begin
            if (n[i])
                k_next = ntc_pkg::K_W'(i);
        end
        x_next = 32'(n) << (5'd31 - k_next);
    end

    always_comb
    begin
        for (int g = 1; g <= F; g++)
            sq_w[g] = 64'(x_reg[g-1]) * 64'(x_reg[g-1]);
    end

    // one fraction bit per squaring; renormalise when the square reaches 2.0
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= x_next;
            k_reg[0] <= k_next;
            for (int g = 1; g < F; g++)
                x_reg[g] <= sq_w[g][63] ? sq_w[g][63:32] : sq_w[g][62:31];
            frac_reg[1] <= F'(sq_w[1][63]) << (F - 1);
            for (int g = 2; g <= F; g++)
                frac_reg[g] <= frac_reg[g-1] | (F'(sq_w[g][63]) << (F - g));
            for (int g = 1; g <= F; g++)
                k_reg[g] <= k_reg[g-1];
        end
    end

    assign log2_val = {k_reg[F], frac_reg[F]};

endmodule
`default_nettype wire

// File: sv/ntc_poly.sv
`default_nettype none
module ntc_poly
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               en,
    input  wire ntc_pkg::ctl_t                      ctl_in,
    input  wire logic [ntc_pkg::LOG_W-1:0]          log_rs,
    input  wire logic [ntc_pkg::LOG_W-1:0]          log_v,
    input  wire logic [ntc_pkg::LOG_W-1:0]          log_rest,
    input  wire ntc_pkg::cfg_t                      cfg,
    output ntc_pkg::ctl_t                           ctl_out,
    output logic signed [ntc_pkg::D_W-1:0]          d
);

    localparam int LN2_HALF = 2 ** (ntc_pkg::LN2_W - 1);
    localparam int L2_W     = ntc_pkg::LOG_W + 2;
    localparam int LQSQ_W   = 2 * ntc_pkg::LQ_W;
    localparam int SQLQ_W   = ntc_pkg::SQ_W + ntc_pkg::LQ_W;
    localparam int SUM_W    = ntc_pkg::CC_W + 1;

    ntc_pkg::ctl_t ctl_reg [0:ntc_pkg::POLY_LAT-1];
    logic          neg_reg [0:ntc_pkg::POLY_LAT-2];

    logic        [ntc_pkg::MAG_W-1:0]  mag_reg;
    logic        [ntc_pkg::PROD_W-1:0] prod_reg;
    logic        [ntc_pkg::MAG_W-1:0]  lnq_reg;
    logic        [ntc_pkg::LQ_W-1:0]   lq_reg;
    logic        [ntc_pkg::LQ_W-1:0]   lq4_reg;
    logic        [ntc_pkg::SQ_W-1:0]   sq_reg;
    logic        [ntc_pkg::CU_W-1:0]   cu_reg;
    logic        [ntc_pkg::CC_W-1:0]   cc_reg;
    logic        [ntc_pkg::BL_W-1:0]   bl4_reg;
    logic        [ntc_pkg::BL_W-1:0]   bl5_reg;
    logic        [ntc_pkg::BL_W-1:0]   bl6_reg;
    logic signed [ntc_pkg::D_W-1:0]    d_reg;

    logic signed [L2_W-1:0]            l2;
    logic        [L2_W-1:0]            l2_abs;
    logic        [LQSQ_W-1:0]          lq_sq;
    logic        [SQLQ_W-1:0]          sq_lq;
    logic        [SUM_W-1:0]           sum;
    logic signed [ntc_pkg::D_W-1:0]    sum_s;
    logic signed [ntc_pkg::D_W-1:0]    a_s;
    logic signed [ntc_pkg::D_W-1:0]    d_next;

    always_comb
    begin
        l2     = $signed({2'b00, log_rs}) + $signed({2'b00, log_v})
               - $signed({2'b00, log_rest});
        l2_abs = l2[L2_W-1] ? L2_W'(-l2) : L2_W'(l2);
        lq_sq  = LQSQ_W'(lq_reg) * LQSQ_W'(lq_reg);
        sq_lq  = SQLQ_W'(sq_reg) * SQLQ_W'(lq4_reg);
        sum    = SUM_W'(bl6_reg) + SUM_W'(cc_reg);
        sum_s  = $signed(ntc_pkg::D_W'(sum));
        a_s    = $signed(ntc_pkg::D_W'({cfg.coef_a, 16'h0000}));
        d_next = neg_reg[ntc_pkg::POLY_LAT-2] ? a_s - sum_s : a_s + sum_s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ntc_pkg::POLY_LAT; i++)
                ctl_reg[i] <= '0;
        end
        else if (en)
        begin
            ctl_reg[0] <= ctl_in;
            for (int i = 1; i < ntc_pkg::POLY_LAT; i++)
                ctl_reg[i] <= ctl_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg[0] <= l2[L2_W-1];
            for (int i = 1; i < ntc_pkg::POLY_LAT - 1; i++)
                neg_reg[i] <= neg_reg[i-1];
            mag_reg  <= l2_abs[ntc_pkg::MAG_W-1:0];
            prod_reg <= ntc_pkg::PROD_W'(mag_reg) * ntc_pkg::PROD_W'(ntc_pkg::LN2_Q26);
            lnq_reg  <= ntc_pkg::MAG_W'(({1'b0, prod_reg}
                        + (ntc_pkg::PROD_W + 1)'(LN2_HALF)) >> ntc_pkg::LN2_W);
            lq_reg   <= ntc_pkg::LQ_W'(((ntc_pkg::MAG_W + 1)'(lnq_reg)
                        + (ntc_pkg::MAG_W + 1)'(ntc_pkg::LQ_HALF)) >> ntc_pkg::LQ_SHIFT);
            lq4_reg  <= lq_reg;
            sq_reg   <= ntc_pkg::SQ_W'(({1'b0, lq_sq} + (LQSQ_W + 1)'(32768)) >> 16);
            bl4_reg  <= ntc_pkg::BL_W'(cfg.coef_b) * ntc_pkg::BL_W'(lq_reg);
            cu_reg   <= ntc_pkg::CU_W'(({1'b0, sq_lq} + (SQLQ_W + 1)'(32768)) >> 16);
            bl5_reg  <= bl4_reg;
            cc_reg   <= ntc_pkg::CC_W'(cfg.coef_c) * ntc_pkg::CC_W'(cu_reg);
            bl6_reg  <= bl5_reg;
            d_reg    <= d_next;
        end
    end

    assign ctl_out = ctl_reg[ntc_pkg::POLY_LAT-1];
    assign d       = d_reg;

endmodule
`default_nettype wire

// File: sv/ntc_div.sv
`default_nettype none
module ntc_div
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             en,
    input  wire ntc_pkg::ctl_t                    ctl_in,
    input  wire logic signed [ntc_pkg::D_W-1:0]   d,
    output ntc_pkg::ctl_t                         ctl_out,
    output logic signed [15:0]                    temp_centi,
    output logic        [1:0]                     status
);

    localparam int QW = ntc_pkg::Q_W;

    typedef struct packed {
        logic dzero;
        logic dneg;
        logic sat;
    } flags_t;

    ntc_pkg::ctl_t ctl_reg [0:ntc_pkg::DIV_LAT-1];

    logic [ntc_pkg::UD_W-1:0] ud0_reg;
    logic [ntc_pkg::N_W-1:0]  n0_reg;
    logic                     dzero0_reg;
    logic                     dneg0_reg;

    logic [ntc_pkg::R_W-1:0]  r_reg  [0:QW-1];
    logic [ntc_pkg::UD_W-1:0] ud_reg [0:QW-1];
    logic [QW-1:0]            q_reg  [0:QW];
    flags_t                   fl_reg [0:QW];

    logic [ntc_pkg::R_W-1:0]  dv_w   [0:QW-1];
    logic                     ge_w   [0:QW-1];

    logic signed [15:0]       temp_reg;
    logic        [1:0]        status_reg;
    logic signed [15:0]       temp_next;
    logic signed [16:0]       t_off;

    always_comb
    begin
        for (int j = 0; j < QW; j++)
        begin
            dv_w[j] = ntc_pkg::R_W'(ud_reg[j]) << (QW - 1 - j);
            ge_w[j] = r_reg[j] >= dv_w[j];
        end
    end

    always_comb
    begin
        t_off = $signed({1'b0, q_reg[QW]}) - ntc_pkg::KELVIN_CENTI;
        if (ctl_reg[ntc_pkg::DIV_LAT-2].status != ntc_pkg::ST_OK)
            temp_next = 16'sd0;
        else if (fl_reg[QW].dzero)
            temp_next = ntc_pkg::TEMP_MAX;
        else if (fl_reg[QW].dneg)
            temp_next = ntc_pkg::TEMP_MIN;
        else if (fl_reg[QW].sat || (q_reg[QW] > ntc_pkg::Q_MAX))
            temp_next = ntc_pkg::TEMP_MAX;
        else
            temp_next = t_off[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ntc_pkg::DIV_LAT; i++)
                ctl_reg[i] <= '0;
        end
        else if (en)
        begin
            ctl_reg[0] <= ctl_in;
            for (int i = 1; i < ntc_pkg::DIV_LAT; i++)
                ctl_reg[i] <= ctl_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // rounding: numerator carries half the divisor
            ud0_reg    <= d[ntc_pkg::UD_W-1:0];
            n0_reg     <= ntc_pkg::N_W'(ntc_pkg::NUM_T)
                        + ntc_pkg::N_W'(d[ntc_pkg::UD_W-1:1]);
            dzero0_reg <= (d == '0);
            dneg0_reg  <= d[ntc_pkg::D_W-1];

            // quotient of 2^16 or more saturates; the bit loop then needs no guard
            r_reg[0]        <= ntc_pkg::R_W'(n0_reg);
            ud_reg[0]       <= ud0_reg;
            q_reg[0]        <= '0;
            fl_reg[0].dzero <= dzero0_reg;
            fl_reg[0].dneg  <= dneg0_reg;
            fl_reg[0].sat   <= ntc_pkg::R_W'(n0_reg) >= {ud0_reg, {QW{1'b0}}};

            for (int j = 0; j < QW - 1; j++)
            begin
                r_reg[j+1]  <= ge_w[j] ? r_reg[j] - dv_w[j] : r_reg[j];
                ud_reg[j+1] <= ud_reg[j];
            end
            for (int j = 0; j < QW; j++)
            begin
                q_reg[j+1]  <= q_reg[j] | (QW'(ge_w[j]) << (QW - 1 - j));
                fl_reg[j+1] <= fl_reg[j];
            end

            temp_reg   <= temp_next;
            status_reg <= ctl_reg[ntc_pkg::DIV_LAT-2].status;
        end
    end

    assign ctl_out    = ctl_reg[ntc_pkg::DIV_LAT-1];
    assign temp_centi = temp_reg;
    assign status     = status_reg;

endmodule
`default_nettype wire

// File: sv/ntc_voltage_to_temperature_unit.sv
// NTC thermistor linearisation: divider voltage in, temperature out.
//
// Sample channel: voltage_mv with sample_valid / sample_stall. A transaction
// takes place at a rising edge with sample_valid high and sample_stall low.
// Result channel: temp_centi (0.01 degC, signed) and status with
// result_valid / result_stall, same rule.
// Configuration: APB write/read of supply, series resistor and the three
// Steinhart-Hart coefficients; write only while the pipeline is empty.
// Throughput: one sample per cycle unless a stalled result holds the
// pipeline. The data path runs through the three squaring chains of the
// log2 units (one fraction bit per stage) and the 16-stage restoring
// divider for the reciprocal.
// Status 1 (voltage at or above supply) and 2 (zero voltage) return zero.
// Reset empties the pipeline, clears result_valid and loads default
// registers. While result_stall holds a waiting result, the pipeline keeps
// advancing into empty stages and stalls the sample side only once the
// stage behind the output register is full.
`default_nettype none
module ntc_voltage_to_temperature_unit
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [ntc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                      pwdata,
    output logic      [31:0]                      prdata,
    output logic                                  pready,
    input  wire logic                             sample_valid,
    output logic                                  sample_stall,
    input  wire logic [12:0]                      voltage_mv,
    output logic                                  result_valid,
    input  wire logic                             result_stall,
    output logic signed [15:0]                    temp_centi,
    output logic        [1:0]                     status
);

    ntc_pkg::cfg_t cfg;
    ntc_pkg::ctl_t ctl0_reg;
    ntc_pkg::ctl_t ctl0_next;
    ntc_pkg::ctl_t ctl_log_reg [0:ntc_pkg::LOG_LAT-1];
    ntc_pkg::ctl_t poly_ctl;
    ntc_pkg::ctl_t div_ctl;

    logic [ntc_pkg::LOG_IN_W-1:0] n_rs_reg;
    logic [ntc_pkg::LOG_IN_W-1:0] n_v_reg;
    logic [ntc_pkg::LOG_IN_W-1:0] n_rest_reg;
    logic [ntc_pkg::LOG_W-1:0]    log_rs;
    logic [ntc_pkg::LOG_W-1:0]    log_v;
    logic [ntc_pkg::LOG_W-1:0]    log_rest;

    logic signed [ntc_pkg::D_W-1:0] d;
    logic signed [15:0]             div_temp;
    logic        [1:0]              div_status;

    logic               en;
    logic               result_valid_reg;
    logic signed [15:0] temp_reg;
    logic        [1:0]  status_reg;
    logic        [12:0] rest_mv;

    // hold everything only when the output and the stage behind it are both full
    assign en           = !(result_valid_reg && result_stall && div_ctl.valid);
    assign sample_stall = !en;
    assign rest_mv      = cfg.supply_mv - voltage_mv;

    always_comb
    begin
        ctl0_next.valid = sample_valid;
        if (voltage_mv >= cfg.supply_mv)
            ctl0_next.status = ntc_pkg::ST_OVER;
        else if (voltage_mv == 13'd0)
            ctl0_next.status = ntc_pkg::ST_ZERO;
        else
            ctl0_next.status = ntc_pkg::ST_OK;
    end

    ntc_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl0_reg <= '0;
            for (int i = 0; i < ntc_pkg::LOG_LAT; i++)
                ctl_log_reg[i] <= '0;
        end
        else if (en)
        begin
            ctl0_reg       <= ctl0_next;
            ctl_log_reg[0] <= ctl0_reg;
            for (int i = 1; i < ntc_pkg::LOG_LAT; i++)
                ctl_log_reg[i] <= ctl_log_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // a zero series resistor counts as one ohm
            n_rs_reg   <= (cfg.series_ohms == 20'd0) ? 20'd1 : cfg.series_ohms;
            n_v_reg    <= ntc_pkg::LOG_IN_W'(voltage_mv);
            n_rest_reg <= ntc_pkg::LOG_IN_W'(rest_mv);
        end
    end

    ntc_log2 u_log_rs
    (
        .clk      (clk),
        .en       (en),
        .n        (n_rs_reg),
        .log2_val (log_rs)
    );

    ntc_log2 u_log_v
    (
        .clk      (clk),
        .en       (en),
        .n        (n_v_reg),
        .log2_val (log_v)
    );

    ntc_log2 u_log_rest
    (
        .clk      (clk),
        .en       (en),
        .n        (n_rest_reg),
        .log2_val (log_rest)
    );

    ntc_poly u_poly
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .ctl_in   (ctl_log_reg[ntc_pkg::LOG_LAT-1]),
        .log_rs   (log_rs),
        .log_v    (log_v),
        .log_rest (log_rest),
        .cfg      (cfg),
        .ctl_out  (poly_ctl),
        .d        (d)
    );

    ntc_div u_div
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .ctl_in     (poly_ctl),
        .d          (d),
        .ctl_out    (div_ctl),
        .temp_centi (div_temp),
        .status     (div_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (!result_valid_reg || !result_stall)
            result_valid_reg <= div_ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (!result_valid_reg || !result_stall)
        begin
            temp_reg   <= div_temp;
            status_reg <= div_status;
        end
    end

    assign result_valid = result_valid_reg;
    assign temp_centi   = temp_reg;
    assign status       = status_reg;

endmodule
`default_nettype wire

// File: sv/ntc_checker.sv
`default_nettype none
`include "ntc_voltage_to_temperature_unit_macros.svh"
module ntc_checker
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               sample_valid,
    input wire logic               sample_stall,
    input wire logic               result_valid,
    input wire logic               result_stall,
    input wire logic signed [15:0] temp_centi,
    input wire logic        [1:0]  status
);

    `NTC_ASSERT_NEXT(a_result_held, clk, rst_n, result_valid && result_stall, result_valid, "result dropped while stalled")
    `NTC_ASSERT_NOW(a_no_stall_when_empty, clk, rst_n, !result_valid, !sample_stall, "sample side stalled with empty output")
    `NTC_ASSERT_NOW(a_status_code, clk, rst_n, result_valid, (status == ntc_pkg::ST_OK) || (status == ntc_pkg::ST_OVER) || (status == ntc_pkg::ST_ZERO), "undefined status code")
    `NTC_ASSERT_NOW(a_error_zero, clk, rst_n, result_valid && (status != ntc_pkg::ST_OK), temp_centi == 16'sd0, "error result with non-zero temperature")
    `NTC_ASSERT_NOW(a_temp_floor, clk, rst_n, result_valid, temp_centi >= ntc_pkg::TEMP_MIN, "temperature below absolute zero")

endmodule

bind ntc_voltage_to_temperature_unit ntc_checker u_ntc_checker (.*);
`default_nettype wire

// File: sim/tb_ntc_voltage_to_temperature_unit.sv
`default_nettype none
module tb_ntc_voltage_to_temperature_unit;

    localparam int PIPE_LAT    = ntc_pkg::FRAC_BITS + 30;
    localparam int CYCLE_LIMIT = 800000;

    typedef longint unsigned u64_t;

    typedef struct {
        logic signed [15:0] temp;
        logic [1:0]         st;
    } temp_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ntc_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        sample_valid = 1'b0;
    logic        sample_stall;
    logic [12:0] voltage_mv = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic signed [15:0] temp_centi;
    logic [1:0]  status;

    // predictor copy of the register file
    logic [12:0] cur_supply = 13'd3300;
    logic [19:0] cur_series = 20'd10000;
    logic [31:0] cur_a = 32'd1129000000;
    logic [31:0] cur_b = 32'd234100000;
    logic [31:0] cur_c = 32'd87670;

    temp_result_t pending_temps[$];
    int  error_count = 0;
    int  samples_sent = 0;
    int  results_seen = 0;
    int  cfg_writes = 0;
    int  cycle_count = 0;
    bit  no_idle = 1'b0;
    int  hold_request = 0;
    int  hold_left = 0;
    int  stall_left = 0;

    ntc_voltage_to_temperature_unit dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .sample_valid(sample_valid), .sample_stall(sample_stall),
        .voltage_mv(voltage_mv),
        .result_valid(result_valid), .result_stall(result_stall),
        .temp_centi(temp_centi), .status(status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("ntc_voltage_to_temperature_unit test failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // log2 in Q(FRAC_BITS): mantissa in Q31, squared once per fraction bit
    function automatic longint unsigned log2_q(longint unsigned n);
        int k;
        longint unsigned x;
        longint unsigned frac;
        k = 0;
        frac = 0;
        while (k < 31 && (n >> (k + 1)) != 0)
            k++;
        x = n << (31 - k);
        for (int i = 1; i <= ntc_pkg::FRAC_BITS; i++)
        begin
            x = (x * x) >> 31;
            if (x >= 64'h1_0000_0000)
            begin
                x = x >> 1;
                frac |= 64'd1 << (ntc_pkg::FRAC_BITS - i);
            end
        end
        return (u64_t'(k) << ntc_pkg::FRAC_BITS) | frac;
    endfunction

    function automatic longint unsigned round_shr(longint unsigned m, int s);
        if (s <= 0)
            return m;
        return (m + (64'd1 << (s - 1))) >> s;
    endfunction

    function automatic temp_result_t predict_temperature(logic [12:0] v);
        temp_result_t res;
        longint unsigned rs, mag, lnq, lq, sq, cu, ud, q;
        longint l2, lsig, l3, d, t;
        bit neg;
        res.temp = '0;
        if (v >= cur_supply)
        begin
            res.st = ntc_pkg::ST_OVER;
            return res;
        end
        if (v == 0)
        begin
            res.st = ntc_pkg::ST_ZERO;
            return res;
        end
        rs = (cur_series == 0) ? 64'd1 : u64_t'(cur_series);
        l2 = longint'(log2_q(rs)) + longint'(log2_q(v)) - longint'(log2_q(cur_supply - v));
        neg = l2 < 0;
        mag = neg ? u64_t'(-l2) : u64_t'(l2);
        lnq = round_shr(mag * 64'd46516320, 26);
        lq = round_shr(lnq, ntc_pkg::FRAC_BITS - 16);
        sq = round_shr(lq * lq, 16);
        cu = round_shr(sq * lq, 16);
        lsig = neg ? -longint'(lq) : longint'(lq);
        l3 = neg ? -longint'(cu) : longint'(cu);
        d = (longint'(cur_a) <<< 16) + longint'(cur_b) * lsig + longint'(cur_c) * l3;
        if (d == 0)
            t = 32767;
        else if (d < 0)
            t = -27316;
        else
        begin
            ud = u64_t'(d);
            q = (64'd6553600000000000000 + ud / 2) / ud;
            if (q > 64'd60083)
                t = 32767;
            else
                t = longint'(q) - 27316;
        end
        res.temp = t[15:0];
        res.st = ntc_pkg::ST_OK;
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0d] mismatch on %s: got %0d, expected %0d", cycle_count, what, got, want);
        error_count++;
    endtask

    // receiver: random stalls, plus long hold-offs on request
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (no_idle)
            result_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            stall_left = pick_gap();
            result_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    always @(posedge clk)
    begin
        temp_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (pending_temps.size() == 0)
                report_mismatch("unexpected result", temp_centi, 0);
            else
            begin
                want = pending_temps.pop_front();
                if (temp_centi !== want.temp)
                    report_mismatch("temp_centi", temp_centi, want.temp);
                if (status !== want.st)
                    report_mismatch("status", status, want.st);
            end
        end
    end

    task automatic send_sample(logic [12:0] v);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            sample_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        sample_valid <= 1'b1;
        voltage_mv <= v;
        do
            @(posedge clk);
        while (sample_stall);
        pending_temps.push_back(predict_temperature(v));
        samples_sent++;
    endtask

    task automatic stop_sending();
        @(negedge clk);
        sample_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_temps.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 6) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ntc_pkg::CFG_ADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            ntc_pkg::REG_SUPPLY: cur_supply = value[12:0];
            ntc_pkg::REG_SERIES: cur_series = value[19:0];
            ntc_pkg::REG_COEF_A: cur_a = value;
            ntc_pkg::REG_COEF_B: cur_b = value;
            ntc_pkg::REG_COEF_C: cur_c = value;
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic set_config(logic [12:0] sup, logic [19:0] ser,
                              logic [31:0] a, logic [31:0] b, logic [31:0] c);
        stop_sending();
        wait_drained();
        write_reg(ntc_pkg::REG_SUPPLY, 32'(sup));
        write_reg(ntc_pkg::REG_SERIES, 32'(ser));
        write_reg(ntc_pkg::REG_COEF_A, a);
        write_reg(ntc_pkg::REG_COEF_B, b);
        write_reg(ntc_pkg::REG_COEF_C, c);
    endtask

    // mostly in-range voltages, some zero and at or above supply
    function automatic logic [12:0] pick_voltage();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4 || cur_supply < 2)
            return 13'd0;
        else if (r < 10)
            return 13'($urandom_range(cur_supply, 8191));
        else
            return 13'($urandom_range(1, cur_supply - 1));
    endfunction

    task automatic test_default_registers();
        logic [12:0] pts[$];
        pts = '{13'd0, 13'd1, 13'd2, 13'd1650, 13'd2730, 13'd4095, 13'd3299,
                13'd3300, 13'd3301, 13'd5000, 13'd8191, 13'd100, 13'd3200};
        foreach (pts[i])
            send_sample(pts[i]);
    endtask

    task automatic test_register_extremes();
        // zero supply: every voltage is over range
        set_config(13'd0, 20'd10000, 32'd1129000000, 32'd234100000, 32'd87670);
        send_sample(13'd0);
        send_sample(13'd7);
        // zero series resistor counts as one ohm
        set_config(13'd5000, 20'd0, 32'd1129000000, 32'd234100000, 32'd87670);
        send_sample(13'd2500);
        send_sample(13'd4999);
        // all coefficients zero: zero denominator
        set_config(13'd1000, 20'd100, 32'd0, 32'd0, 32'd0);
        send_sample(13'd1);
        send_sample(13'd999);
        // extreme coefficients and series resistors: very cold results
        set_config(13'd8191, 20'hFFFFF, 32'd0, 32'd4000000000, 32'd4000000000);
        send_sample(13'd1);
        send_sample(13'd8190);
        send_sample(13'd4096);
        set_config(13'd5000, 20'd1000000, 32'd4000000000, 32'd0, 32'hFFFFFFFF);
        send_sample(13'd1);
        send_sample(13'd4999);
        send_sample(13'd2500);
    endtask

    task automatic test_random_settings(int phases, int per_phase);
        for (int p = 0; p < phases; p++)
        begin
            if (p % 3 == 2)
                set_config(13'($urandom), 20'($urandom), $urandom, $urandom, $urandom);
            else
                set_config(13'($urandom_range(1000, 5000)),
                           20'($urandom_range(100, 1000000)),
                           $urandom_range(500000000, 2000000000),
                           $urandom_range(100000000, 400000000),
                           $urandom_range(0, 200000));
            no_idle = (p % 4 == 1);
            repeat (per_phase)
                send_sample(pick_voltage());
            no_idle = 1'b0;
        end
    endtask

    task automatic test_backpressure();
        set_config(13'd3300, 20'd10000, 32'd1129000000, 32'd234100000, 32'd87670);
        @(posedge clk);
        hold_request = 400;
        no_idle = 1'b1;
        repeat (150)
            send_sample(pick_voltage());
        no_idle = 1'b0;
    endtask

    task automatic test_paused_sender();
        repeat (20)
            send_sample(pick_voltage());
        stop_sending();
        while (pending_temps.size() != 0)
            @(posedge clk);
        repeat (20)
            send_sample(pick_voltage());
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_default_registers();
        test_register_extremes();
        test_random_settings(6, 260);
        test_backpressure();
        test_paused_sender();
        stop_sending();
        wait_drained();
        $display("covered %0d samples, %0d results, %0d register writes",
                 samples_sent, results_seen, cfg_writes);
        $display("settings included zero supply, zero resistor, zero and extreme coefficients");
        if (error_count == 0)
            $display("ntc_voltage_to_temperature_unit test passed");
        else
            $display("ntc_voltage_to_temperature_unit test failed");
        $finish;
    end
endmodule
`default_nettype wire

// File: files.f
+incdir+sv
sv/ntc_pkg.sv
sv/ntc_cfg.sv
sv/ntc_log2.sv
sv/ntc_poly.sv
sv/ntc_div.sv
sv/ntc_voltage_to_temperature_unit.sv
sv/ntc_checker.sv
sim/tb_ntc_voltage_to_temperature_unit.sv
